/* rtl/core/aier_pkg.sv */
// Shared constants and types of the ARP and ICMP echo responder.
`timescale 1ns / 1ps
package aier_pkg;

  localparam int MAX_FRAME     = 512;
  localparam int ADDR_W        = $clog2(MAX_FRAME);
  localparam int LEN_W         = $clog2(MAX_FRAME + 1);
  localparam int HDR_LEN       = 42;
  localparam int HDR_W         = $clog2(HDR_LEN);
  localparam int ARP_FRAME_LEN = 42;
  localparam int MIN_ECHO_LEN  = 50;
  localparam int BEAT_BYTES    = 8;
  localparam int LANE_W        = $clog2(BEAT_BYTES);
  localparam int HSUM_W        = 19;
  localparam int CSUM_W        = 24;

  localparam logic KIND_ARP  = 1'b0;
  localparam logic KIND_ECHO = 1'b1;

  localparam logic CFG_OWN_MAC = 1'b0;
  localparam logic CFG_OWN_IP  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [LEN_W-1:0]  len;
    logic [15:0]       id_new;
    logic [HSUM_W-1:0] hsum;
    logic [CSUM_W-1:0] csum;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

endpackage

/* rtl/core/aier_rx.sv */
// Receive front: stores frame bytes, keeps header copy and sums, classifies at frame end.
`timescale 1ns / 1ps
module aier_rx (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_end,
  input  logic [47:0]          own_mac,
  input  logic [31:0]          own_ip,
  output aier_pkg::mem_wr_t    wr,
  output logic                 push,
  output aier_pkg::job_t       job
);

  logic [aier_pkg::LEN_W-1:0]  cnt_r;
  logic                        ovf_r;
  logic [aier_pkg::HSUM_W-1:0] hsum_r, hsum_nxt;
  logic [aier_pkg::CSUM_W-1:0] csum_r, csum_nxt;
  logic [7:0]                  hdr_r [aier_pkg::HDR_LEN];
  logic [7:0]                  v [aier_pkg::HDR_LEN];
  logic                        store, in_hdr, in_icmp;
  logic [15:0]                 add;
  logic [47:0]                 dst, src;
  logic [31:0]                 arp_tip, ip_dst;
  logic [aier_pkg::LEN_W-1:0]  len;
  logic                        mac_ok, is_arp, is_echo;

  assign store = cnt_r < aier_pkg::LEN_W'(aier_pkg::MAX_FRAME);
  assign len   = cnt_r + 1'b1;

  always_comb begin
    for (int i = 0; i < aier_pkg::HDR_LEN; i++) begin
      v[i] = (cnt_r == aier_pkg::LEN_W'(i)) ? rx_byte : hdr_r[i];
    end
  end

  assign in_hdr = (cnt_r >= 14) && (cnt_r <= 33) && (cnt_r != 18) && (cnt_r != 19) &&
                  (cnt_r != 24) && (cnt_r != 25);
  assign in_icmp = store && (cnt_r >= 34) && (cnt_r != 34) && (cnt_r != 36) &&
                   (cnt_r != 37);
  assign add = cnt_r[0] ? {8'h00, rx_byte} : {rx_byte, 8'h00};
  assign hsum_nxt = in_hdr ? hsum_r + aier_pkg::HSUM_W'(add) : hsum_r;
  assign csum_nxt = in_icmp ? csum_r + aier_pkg::CSUM_W'(add) : csum_r;

  assign dst     = {v[0], v[1], v[2], v[3], v[4], v[5]};
  assign src     = {v[6], v[7], v[8], v[9], v[10], v[11]};
  assign arp_tip = {v[38], v[39], v[40], v[41]};
  assign ip_dst  = {v[30], v[31], v[32], v[33]};
  assign mac_ok  = (dst == 48'hffff_ffff_ffff) || (dst == 48'h0 && src == 48'h0) ||
                   (dst == own_mac);
  assign is_arp  = (len >= aier_pkg::LEN_W'(aier_pkg::ARP_FRAME_LEN)) && v[12] == 8'h08 &&
                   v[13] == 8'h06 && v[20] == 8'h00 && v[21] == 8'h01 && arp_tip == own_ip;
  assign is_echo = (len >= aier_pkg::LEN_W'(aier_pkg::MIN_ECHO_LEN)) &&
                   (len >= aier_pkg::LEN_W'(aier_pkg::HDR_LEN)) && v[12] == 8'h08 &&
                   v[13] == 8'h00 && v[23] == 8'h01 && v[34] == 8'h08 && ip_dst == own_ip;

  assign push = acc && frame_end && store && !ovf_r && mac_ok && (is_arp || is_echo);

  always_comb begin
    job.kind   = is_arp ? aier_pkg::KIND_ARP : aier_pkg::KIND_ECHO;
    job.len    = is_arp ? aier_pkg::LEN_W'(aier_pkg::ARP_FRAME_LEN) : len;
    job.id_new = {v[18], v[19]} + 16'd1;
    job.hsum   = hsum_nxt;
    job.csum   = csum_nxt;
  end

  assign wr.en   = acc && store;
  assign wr.addr = cnt_r[aier_pkg::ADDR_W-1:0];
  assign wr.data = rx_byte;

  always_ff @(posedge clk) begin
    if (acc && cnt_r < aier_pkg::LEN_W'(aier_pkg::HDR_LEN)) begin
      hdr_r[cnt_r[aier_pkg::HDR_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      hsum_r <= '0;
      csum_r <= '0;
    end else if (acc) begin
      if (frame_end) begin
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
        hsum_r <= '0;
        csum_r <= '0;
      end else begin
        cnt_r  <= store ? cnt_r + 1'b1 : cnt_r;
        ovf_r  <= ovf_r | ~store;
        hsum_r <= hsum_nxt;
        csum_r <= csum_nxt;
      end
    end
  end

endmodule

/* rtl/core/aier_queue.sv */
// Two-entry job queue between the receive front and the transmit back.
`timescale 1ns / 1ps
module aier_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  aier_pkg::job_t  push_job,
  input  logic            pop,
  output logic            not_empty,
  output aier_pkg::job_t  head
);

  aier_pkg::job_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           do_push;

  assign not_empty = cnt_r != 2'd0;
  assign head      = ent_r[rp_r];
  assign do_push   = push && cnt_r != 2'd2;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (pop && not_empty) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(pop && not_empty);
    end
  end

endmodule

/* rtl/core/aier_tx.sv */
// Transmit back: holds the frame store, finishes checksums and emits reply beats.
`timescale 1ns / 1ps
module aier_tx (
  input  logic               clk,
  input  logic               rst_n,
  input  aier_pkg::mem_wr_t  wr,
  input  logic               q_not_empty,
  input  aier_pkg::job_t     q_head,
  output logic               pop,
  output logic               active,
  input  logic [47:0]        own_mac,
  input  logic [31:0]        own_ip,
  output logic               out_strobe,
  output logic [63:0]        out_tx_data,
  output logic [3:0]         out_tx_bytes,
  output logic               out_tx_last,
  output logic               out_reply_kind
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FOLD1 = 2'd1;
  localparam logic [1:0] ST_FOLD2 = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  logic [7:0]                  mem [aier_pkg::MAX_FRAME];
  logic [7:0]                  mem_q_r;
  logic [1:0]                  st_r;
  aier_pkg::job_t              job_r;
  logic [16:0]                 h1_r, c1_r;
  logic [15:0]                 hcs_r, ccs_r;
  logic [aier_pkg::LEN_W-1:0]  rd_off_r, q_off_r;
  logic                        q_vld_r;
  logic [aier_pkg::LANE_W-1:0] lane_r;
  logic [7:0]                  beat_r [aier_pkg::BEAT_BYTES];
  logic [7:0]                  beat_nxt [aier_pkg::BEAT_BYTES];
  logic [aier_pkg::LEN_W-1:0]  rd_addr;
  logic [aier_pkg::HSUM_W:0]   hsum_full;
  logic [16:0]                 h2, c2;
  logic [7:0]                  byte_out;
  logic                        last_byte, emit;
  logic [63:0]                 data_nxt;

  function automatic logic [7:0] mac_b(input logic [47:0] m, input logic [2:0] k);
    return m[8'(47 - 8 * k) -: 8];
  endfunction

  function automatic logic [7:0] ip_b(input logic [31:0] a, input logic [1:0] k);
    return a[6'(31 - 8 * k) -: 8];
  endfunction

  assign active = st_r != ST_IDLE;
  assign pop    = st_r == ST_IDLE && q_not_empty;

  always_comb begin
    rd_addr = rd_off_r;
    if (job_r.kind == aier_pkg::KIND_ARP) begin
      if (rd_off_r <= 5) begin
        rd_addr = rd_off_r + 10'd6;
      end else if (rd_off_r >= 32 && rd_off_r <= 41) begin
        rd_addr = rd_off_r - 10'd10;
      end
    end else begin
      if (rd_off_r <= 5) begin
        rd_addr = rd_off_r + 10'd6;
      end else if (rd_off_r <= 11) begin
        rd_addr = rd_off_r - 10'd6;
      end else if (rd_off_r >= 26 && rd_off_r <= 29) begin
        rd_addr = rd_off_r + 10'd4;
      end else if (rd_off_r >= 30 && rd_off_r <= 33) begin
        rd_addr = rd_off_r - 10'd4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q_r <= mem[rd_addr[aier_pkg::ADDR_W-1:0]];
  end

  always_comb begin
    byte_out = mem_q_r;
    if (job_r.kind == aier_pkg::KIND_ARP) begin
      if (q_off_r >= 6 && q_off_r <= 11) begin
        byte_out = mac_b(own_mac, 3'(q_off_r - 10'd6));
      end else if (q_off_r == 20) begin
        byte_out = 8'h00;
      end else if (q_off_r == 21) begin
        byte_out = 8'h02;
      end else if (q_off_r >= 22 && q_off_r <= 27) begin
        byte_out = mac_b(own_mac, 3'(q_off_r - 10'd22));
      end else if (q_off_r >= 28 && q_off_r <= 31) begin
        byte_out = ip_b(own_ip, 2'(q_off_r - 10'd28));
      end
    end else begin
      if (q_off_r == 18) begin
        byte_out = job_r.id_new[15:8];
      end else if (q_off_r == 19) begin
        byte_out = job_r.id_new[7:0];
      end else if (q_off_r == 24) begin
        byte_out = hcs_r[15:8];
      end else if (q_off_r == 25) begin
        byte_out = hcs_r[7:0];
      end else if (q_off_r == 34) begin
        byte_out = 8'h00;
      end else if (q_off_r == 36) begin
        byte_out = ccs_r[15:8];
      end else if (q_off_r == 37) begin
        byte_out = ccs_r[7:0];
      end
    end
  end

  assign last_byte = q_off_r == job_r.len - 1'b1;
  assign emit      = q_vld_r && (lane_r == aier_pkg::LANE_W'(aier_pkg::BEAT_BYTES - 1) ||
                     last_byte);

  always_comb begin
    for (int i = 0; i < aier_pkg::BEAT_BYTES; i++) begin
      beat_nxt[i] = (lane_r == aier_pkg::LANE_W'(i)) ? byte_out : beat_r[i];
      data_nxt[8 * (aier_pkg::BEAT_BYTES - 1 - i) +: 8] =
        (aier_pkg::LANE_W'(i) <= lane_r) ? beat_nxt[i] : 8'h00;
    end
  end

  assign hsum_full = {1'b0, job_r.hsum} + (aier_pkg::HSUM_W + 1)'(job_r.id_new);
  assign h2        = {1'b0, h1_r[15:0]} + 17'(h1_r[16]);
  assign c2        = {1'b0, c1_r[15:0]} + 17'(c1_r[16]);

  always_ff @(posedge clk) begin
    if (q_vld_r) begin
      beat_r <= beat_nxt;
    end
    if (pop) begin
      job_r <= q_head;
    end
    if (st_r == ST_FOLD1) begin
      h1_r <= {1'b0, hsum_full[15:0]} + 17'(hsum_full[aier_pkg::HSUM_W:16]);
      c1_r <= {1'b0, job_r.csum[15:0]} + 17'(job_r.csum[aier_pkg::CSUM_W-1:16]);
    end
    if (st_r == ST_FOLD2) begin
      hcs_r <= ~h2[15:0];
      ccs_r <= ~c2[15:0];
    end
    if (emit) begin
      out_tx_data    <= data_nxt;
      out_tx_bytes   <= 4'(lane_r) + 4'd1;
      out_tx_last    <= last_byte;
      out_reply_kind <= job_r.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      rd_off_r   <= '0;
      q_off_r    <= '0;
      q_vld_r    <= 1'b0;
      lane_r     <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= emit;
      if (q_vld_r) begin
        lane_r <= emit ? '0 : lane_r + 1'b1;
      end
      unique case (st_r)
        ST_IDLE: begin
          q_vld_r <= 1'b0;
          if (q_not_empty) begin
            st_r <= ST_FOLD1;
          end
        end
        ST_FOLD1: begin
          st_r <= ST_FOLD2;
        end
        ST_FOLD2: begin
          rd_off_r <= '0;
          lane_r   <= '0;
          q_vld_r  <= 1'b0;
          st_r     <= ST_RUN;
        end
        ST_RUN: begin
          if (rd_off_r < job_r.len) begin
            q_vld_r  <= 1'b1;
            q_off_r  <= rd_off_r;
            rd_off_r <= rd_off_r + 1'b1;
          end else begin
            q_vld_r <= 1'b0;
          end
          if (q_vld_r && last_byte) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/arp_icmp_echo_responder_unit.sv */
// Top level of the ARP and ICMP echo responder.
`timescale 1ns / 1ps
// Frame bytes enter one per cycle while start is high and busy is low; the
// byte with in_frame_end closes the frame. Frames that are dropped never raise
// busy. A matching ARP request or ICMP echo request is answered from the
// stored frame: after the final byte, the job passes through the job queue to
// the back end, which folds the checksums in ST_FOLD1 and ST_FOLD2 and then
// issues frame store reads in ST_RUN. One byte is read per cycle there, and
// each beat of up to 8 bytes appears on the out_ ports with out_strobe high
// for a single cycle. After the final byte is accepted busy stays high, and
// the reply's last beat is on the out_ ports in the cycle busy falls; the
// receiver has no way to stall and must take every beat as it comes.
module arp_icmp_echo_responder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  output logic        out_strobe,
  output logic [63:0] out_tx_data,
  output logic [3:0]  out_tx_bytes,
  output logic        out_tx_last,
  output logic        out_reply_kind
);

  logic [47:0]        own_mac_r;
  logic [31:0]        own_ip_r;
  logic               acc, push, pop, q_not_empty, tx_active;
  aier_pkg::job_t     push_job, q_head;
  aier_pkg::mem_wr_t  wr;

  assign busy = q_not_empty || tx_active;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aier_pkg::CFG_OWN_MAC: own_mac_r <= cfg_data;
        aier_pkg::CFG_OWN_IP:  own_ip_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  aier_rx u_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_rx_byte),
    .frame_end (in_frame_end),
    .own_mac   (own_mac_r),
    .own_ip    (own_ip_r),
    .wr        (wr),
    .push      (push),
    .job       (push_job)
  );

  aier_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  aier_tx u_tx (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr             (wr),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .pop            (pop),
    .active         (tx_active),
    .own_mac        (own_mac_r),
    .own_ip         (own_ip_r),
    .out_strobe     (out_strobe),
    .out_tx_data    (out_tx_data),
    .out_tx_bytes   (out_tx_bytes),
    .out_tx_last    (out_tx_last),
    .out_reply_kind (out_reply_kind)
  );

endmodule
